[sv/ebc_pkg.sv]
// Package with shared types and constants for the eight-bit CPU subset core.
package ebc_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_EXEC = 2'd2;

    localparam logic [7:0] FL_S  = 8'h80;
    localparam logic [7:0] FL_Z  = 8'h40;
    localparam logic [7:0] FL_H  = 8'h10;
    localparam logic [7:0] FL_PV = 8'h04;
    localparam logic [7:0] FL_N  = 8'h02;
    localparam logic [7:0] FL_C  = 8'h01;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_LDAN = 8'h3E;
    localparam logic [7:0] OP_LDBN = 8'h06;
    localparam logic [7:0] OP_LDCN = 8'h0E;
    localparam logic [7:0] OP_LDDN = 8'h16;
    localparam logic [7:0] OP_LDEN = 8'h1E;
    localparam logic [7:0] OP_LDHN = 8'h26;
    localparam logic [7:0] OP_LDLN = 8'h2E;
    localparam logic [7:0] OP_LDAB = 8'h78;
    localparam logic [7:0] OP_LDAC = 8'h79;
    localparam logic [7:0] OP_LDAD = 8'h7A;
    localparam logic [7:0] OP_LDAE = 8'h7B;
    localparam logic [7:0] OP_LDAH = 8'h7C;
    localparam logic [7:0] OP_LDAL = 8'h7D;
    localparam logic [7:0] OP_LDBA = 8'h47;
    localparam logic [7:0] OP_LDBC = 8'h41;
    localparam logic [7:0] OP_LDCA = 8'h4F;
    localparam logic [7:0] OP_LDDA = 8'h57;
    localparam logic [7:0] OP_LDEA = 8'h5F;
    localparam logic [7:0] OP_LDHA = 8'h67;
    localparam logic [7:0] OP_LDLA = 8'h6F;
    localparam logic [7:0] OP_ADDN = 8'hC6;
    localparam logic [7:0] OP_SUBN = 8'hD6;
    localparam logic [7:0] OP_ADDA = 8'h87;
    localparam logic [7:0] OP_ADDB = 8'h80;
    localparam logic [7:0] OP_ADDC = 8'h81;
    localparam logic [7:0] OP_ADDD = 8'h82;
    localparam logic [7:0] OP_ADDE = 8'h83;
    localparam logic [7:0] OP_SUBA = 8'h97;
    localparam logic [7:0] OP_SUBB = 8'h90;
    localparam logic [7:0] OP_SUBC = 8'h91;
    localparam logic [7:0] OP_SUBD = 8'h92;
    localparam logic [7:0] OP_SUBE = 8'h93;
    localparam logic [7:0] OP_JP   = 8'hC3;
    localparam logic [7:0] OP_JPZ  = 8'hCA;
    localparam logic [7:0] OP_JPNZ = 8'hC2;
    localparam logic [7:0] OP_JPC  = 8'hDA;
    localparam logic [7:0] OP_JPNC = 8'hD2;
    localparam logic [7:0] OP_CALL = 8'hCD;
    localparam logic [7:0] OP_RET  = 8'hC9;
    localparam logic [7:0] OP_DJNZ = 8'h10;
    localparam logic [7:0] OP_JR   = 8'h18;
    localparam logic [7:0] OP_JRZ  = 8'h28;
    localparam logic [7:0] OP_JRNZ = 8'h20;
    localparam logic [7:0] OP_JRC  = 8'h38;
    localparam logic [7:0] OP_JRNC = 8'h30;
    localparam logic [7:0] OP_ED   = 8'hED;
    localparam logic [7:0] OP_LDIR = 8'hB0;
    localparam logic [7:0] OP_LDDR = 8'hB8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [15:0] pc_out;
        logic [15:0] sp_out;
        logic [7:0]  acc_out;
        logic [7:0]  b_out;
        logic [7:0]  c_out;
        logic [7:0]  d_out;
        logic [7:0]  e_out;
        logic [7:0]  h_out;
        logic [7:0]  l_out;
        logic [7:0]  flag_bits;
        logic        fault;
        logic [7:0]  read_data;
    } t_rsp;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_FETCH,
        ST_DECODE,
        ST_IMM,
        ST_LO,
        ST_HI,
        ST_ED,
        ST_CALL1,
        ST_CALL2,
        ST_RET1,
        ST_RET2,
        ST_CPRD,
        ST_CPWR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flags;
    } t_alu_out;

endpackage

[sv/ebc_alu.sv]
// Shared 8-bit add and subtract unit with flag generation.
module ebc_alu import ebc_pkg::*; (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic       i_sub,
    input  logic [7:0] i_flags,
    output t_alu_out   o_out
);
    logic [8:0] w_r;
    logic [7:0] w_f;

    always_comb begin
        w_r = i_sub ? ({1'b0, i_a} - {1'b0, i_b}) : ({1'b0, i_a} + {1'b0, i_b});
        w_f = 8'h00;
        if (w_r[7:0] == 8'h00) w_f = w_f | FL_Z;
        if (w_r[7]) w_f = w_f | FL_S;
        if (w_r[8]) w_f = w_f | FL_C;
        if (i_sub) begin
            w_f = w_f | FL_N;
            if (((i_a ^ i_b) & (i_a ^ w_r[7:0]) & 8'h80) != 8'h00) w_f = w_f | FL_PV;
            if (i_a[3:0] < i_b[3:0]) w_f = w_f | FL_H;
        end else begin
            if ((~(i_a ^ i_b) & (i_a ^ w_r[7:0]) & 8'h80) != 8'h00) w_f = w_f | FL_PV;
            if (({1'b0, i_a[3:0]} + {1'b0, i_b[3:0]}) > 5'h0F) w_f = w_f | FL_H;
        end
        o_out.res   = w_r[7:0];
        o_out.flags = (i_flags & 8'h28) | w_f;
    end
endmodule

[sv/eight_bit_cpu_instruction_subset.sv]
// Top level of the eight-bit CPU subset core with its internal byte memory.
// A request is taken when start is high and busy is low; its single
// result appears for one cycle with o_done high and cannot be stalled.
// After reset the core first clears its memory, one byte per cycle, with busy
// high. A load request writes its byte in the accepting cycle, a read request
// registers the memory data before its result, and an execute request once
// the sticky fault is set goes straight to its result, as a load does.
// An instruction fetches the opcode and decodes it, then takes a further step
// for each operand byte, stack access or ALU step; NOP, register moves and
// unknown opcodes finish after decoding. LDIR/LDDR take a read and a write
// step for every byte copied (BC of them). The unit shares one adder for
// the ALU.
module eight_bit_cpu_instruction_subset import ebc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp
);
    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    logic [15:0] r_pc, r_sp, r_tmp, r_clr;
    logic [7:0]  r_a, r_f, r_op, r_b, r_c, r_d, r_e, r_h, r_l, r_rd;
    logic        r_fault;

    logic        w_we;
    logic [15:0] w_addr;
    logic [7:0]  w_wd;
    t_alu_out    w_alu;
    logic [7:0]  w_alu_b;
    logic        w_alu_sub;

    logic [15:0] w_hl, w_de, w_bc;
    assign w_hl = {r_h, r_l};
    assign w_de = {r_d, r_e};
    assign w_bc = {r_b, r_c};

    // The memory is clocked with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr[MEM_AW-1:0]] <= w_wd;
        r_rdata <= r_mem[w_addr[MEM_AW-1:0]];
    end

    ebc_alu u_alu (
        .i_a(r_a), .i_b(w_alu_b), .i_sub(w_alu_sub), .i_flags(r_f), .o_out(w_alu)
    );

    // Memory port selection by state.
    always_comb begin
        w_we = 1'b0;
        w_addr = r_pc;
        w_wd = 8'h00;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1; w_addr = r_clr;
            end
            ST_IDLE: begin
                w_addr = i_req.address;
                w_we = start && (i_req.kind == KIND_LOAD);
                w_wd = i_req.write_data;
            end
            ST_CALL1: begin
                w_we = 1'b1; w_addr = r_sp - 16'd1; w_wd = r_pc[15:8];
            end
            ST_CALL2: begin
                w_we = 1'b1; w_addr = r_sp - 16'd1; w_wd = r_pc[7:0];
            end
            ST_RET1: w_addr = r_sp;
            ST_RET2: w_addr = r_sp;
            ST_CPRD: w_addr = w_hl;
            ST_CPWR: begin
                w_we = 1'b1; w_addr = w_de; w_wd = r_rdata;
            end
            default: w_addr = r_pc;
        endcase
    end

    // ALU operand comes from the immediate byte or a register.
    always_comb begin
        w_alu_sub = (r_op == OP_SUBN) || (r_op[7:4] == 4'h9);
        case (r_op[2:0])
            3'd0: w_alu_b = r_b;
            3'd1: w_alu_b = r_c;
            3'd2: w_alu_b = r_d;
            3'd3: w_alu_b = r_e;
            3'd7: w_alu_b = r_a;
            default: w_alu_b = r_rdata;
        endcase
    end

    logic w_z, w_cy;
    assign w_z  = r_f[6];
    assign w_cy = r_f[0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == 16'(MEM_BYTES - 1)) n_state = ST_IDLE;
            ST_IDLE: if (start) begin
                if (i_req.kind == KIND_READ) n_state = ST_RDWAIT;
                else if (i_req.kind == KIND_EXEC && !r_fault) n_state = ST_FETCH;
                else n_state = ST_DONE;
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_FETCH: n_state = ST_DECODE;
            ST_DECODE: begin
                case (r_rdata)
                    OP_NOP, OP_LDAB, OP_LDAC, OP_LDAD, OP_LDAE, OP_LDAH, OP_LDAL,
                    OP_LDBA, OP_LDBC, OP_LDCA, OP_LDDA, OP_LDEA, OP_LDHA,
                    OP_LDLA: n_state = ST_DONE;
                    // Register ADD/SUB use the ALU step too, with a register operand.
                    OP_ADDA, OP_ADDB, OP_ADDC, OP_ADDD, OP_ADDE,
                    OP_SUBA, OP_SUBB, OP_SUBC, OP_SUBD, OP_SUBE,
                    OP_LDAN, OP_LDBN, OP_LDCN, OP_LDDN, OP_LDEN, OP_LDHN, OP_LDLN,
                    OP_ADDN, OP_SUBN, OP_DJNZ, OP_JR, OP_JRZ, OP_JRNZ, OP_JRC,
                    OP_JRNC: n_state = ST_IMM;
                    OP_JP, OP_JPZ, OP_JPNZ, OP_JPC, OP_JPNC, OP_CALL: n_state = ST_LO;
                    OP_RET: n_state = ST_RET1;
                    OP_ED: n_state = ST_ED;
                    default: n_state = ST_DONE;
                endcase
            end
            ST_IMM: n_state = ST_DONE;
            ST_LO: n_state = ST_HI;
            ST_HI: n_state = (r_op == OP_CALL) ? ST_CALL1 : ST_DONE;
            ST_CALL1: n_state = ST_CALL2;
            ST_CALL2: n_state = ST_DONE;
            ST_RET1: n_state = ST_RET2;
            // The high return byte arrives in the HI cycle, which loads the PC.
            ST_RET2: n_state = ST_HI;
            ST_ED: begin
                if ((r_rdata == OP_LDIR || r_rdata == OP_LDDR) && w_bc != 16'h0000)
                    n_state = ST_CPRD;
                else n_state = ST_DONE;
            end
            ST_CPRD: n_state = ST_CPWR;
            ST_CPWR: n_state = (w_bc == 16'h0001) ? ST_DONE : ST_CPRD;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_rsp.pc_out = r_pc;
        o_rsp.sp_out = r_sp;
        o_rsp.acc_out = r_a;
        o_rsp.b_out = r_b;
        o_rsp.c_out = r_c;
        o_rsp.d_out = r_d;
        o_rsp.e_out = r_e;
        o_rsp.h_out = r_h;
        o_rsp.l_out = r_l;
        o_rsp.flag_bits = r_f;
        o_rsp.fault = r_fault;
        o_rsp.read_data = r_rd;
    end

    logic [15:0] w_rel;
    assign w_rel = r_pc + {{8{r_rdata[7]}}, r_rdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= 16'h0000;
            r_pc <= 16'h0000;
            r_sp <= 16'hFFFF;
            r_a <= 8'h00; r_f <= 8'h00;
            r_b <= 8'h00; r_c <= 8'h00; r_d <= 8'h00;
            r_e <= 8'h00; r_h <= 8'h00; r_l <= 8'h00;
            r_fault <= 1'b0;
            r_rd <= 8'h00;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 16'd1;
                ST_IDLE: if (start) begin
                    r_rd <= 8'h00;
                end
                ST_RDWAIT: r_rd <= r_rdata;
                ST_FETCH: r_pc <= r_pc + 16'd1;
                ST_DECODE: begin
                    r_op <= r_rdata;
                    case (r_rdata)
                        OP_LDAB: r_a <= r_b;
                        OP_LDAC: r_a <= r_c;
                        OP_LDAD: r_a <= r_d;
                        OP_LDAE: r_a <= r_e;
                        OP_LDAH: r_a <= r_h;
                        OP_LDAL: r_a <= r_l;
                        OP_LDBA: r_b <= r_a;
                        OP_LDBC: r_b <= r_c;
                        OP_LDCA: r_c <= r_a;
                        OP_LDDA: r_d <= r_a;
                        OP_LDEA: r_e <= r_a;
                        OP_LDHA: r_h <= r_a;
                        OP_LDLA: r_l <= r_a;
                        OP_DJNZ: begin
                            r_b <= r_b - 8'd1;
                            r_pc <= r_pc + 16'd1;
                        end
                        OP_NOP, OP_RET: ;
                        OP_LDAN, OP_LDBN, OP_LDCN, OP_LDDN, OP_LDEN, OP_LDHN, OP_LDLN,
                        OP_ADDN, OP_SUBN, OP_JR, OP_JRZ, OP_JRNZ, OP_JRC, OP_JRNC,
                        OP_JP, OP_JPZ, OP_JPNZ, OP_JPC, OP_JPNC, OP_CALL, OP_ED:
                            r_pc <= r_pc + 16'd1;
                        OP_ADDA, OP_ADDB, OP_ADDC, OP_ADDD, OP_ADDE,
                        OP_SUBA, OP_SUBB, OP_SUBC, OP_SUBD, OP_SUBE: ;
                        default: r_fault <= 1'b1;
                    endcase
                end
                ST_IMM: begin
                    case (r_op)
                        OP_LDAN: r_a <= r_rdata;
                        OP_LDBN: r_b <= r_rdata;
                        OP_LDCN: r_c <= r_rdata;
                        OP_LDDN: r_d <= r_rdata;
                        OP_LDEN: r_e <= r_rdata;
                        OP_LDHN: r_h <= r_rdata;
                        OP_LDLN: r_l <= r_rdata;
                        OP_ADDN, OP_SUBN,
                        OP_ADDA, OP_ADDB, OP_ADDC, OP_ADDD, OP_ADDE,
                        OP_SUBA, OP_SUBB, OP_SUBC, OP_SUBD, OP_SUBE: begin
                            r_a <= w_alu.res; r_f <= w_alu.flags;
                        end
                        OP_DJNZ: if (r_b != 8'h00) r_pc <= w_rel;
                        OP_JR: r_pc <= w_rel;
                        OP_JRZ: if (w_z) r_pc <= w_rel;
                        OP_JRNZ: if (!w_z) r_pc <= w_rel;
                        OP_JRC: if (w_cy) r_pc <= w_rel;
                        OP_JRNC: if (!w_cy) r_pc <= w_rel;
                        default: ;
                    endcase
                end
                ST_LO: begin
                    r_tmp[7:0] <= r_rdata;
                    r_pc <= r_pc + 16'd1;
                end
                ST_HI: begin
                    case (r_op)
                        OP_JP: r_pc <= {r_rdata, r_tmp[7:0]};
                        OP_JPZ: if (w_z) r_pc <= {r_rdata, r_tmp[7:0]};
                        OP_JPNZ: if (!w_z) r_pc <= {r_rdata, r_tmp[7:0]};
                        OP_JPC: if (w_cy) r_pc <= {r_rdata, r_tmp[7:0]};
                        OP_JPNC: if (!w_cy) r_pc <= {r_rdata, r_tmp[7:0]};
                        OP_RET: r_pc <= {r_rdata, r_tmp[7:0]};
                        default: r_tmp[15:8] <= r_rdata;
                    endcase
                end
                ST_CALL1: r_sp <= r_sp - 16'd1;
                ST_CALL2: begin
                    r_sp <= r_sp - 16'd1;
                    r_pc <= r_tmp;
                end
                ST_RET1: r_sp <= r_sp + 16'd1;
                ST_RET2: begin
                    r_sp <= r_sp + 16'd1;
                    r_tmp[7:0] <= r_rdata;
                end
                ST_ED: begin
                    r_op <= r_rdata;
                    if (r_rdata == OP_LDIR || r_rdata == OP_LDDR)
                        r_f <= r_f & ~(FL_H | FL_PV | FL_N);
                    else r_fault <= 1'b1;
                end
                ST_CPWR: begin
                    {r_b, r_c} <= w_bc - 16'd1;
                    if (r_op == OP_LDIR) begin
                        {r_h, r_l} <= w_hl + 16'd1;
                        {r_d, r_e} <= w_de + 16'd1;
                    end else begin
                        {r_h, r_l} <= w_hl - 16'd1;
                        {r_d, r_e} <= w_de - 16'd1;
                    end
                end
                default: ;
            endcase
            if (r_state == ST_FETCH) r_op <= OP_NOP;
        end
    end
endmodule
